[rtl/remote_command_latch_decoder_top_assert.svh]
// Assertion macros used by the checker file of the remote command latch decoder.
`ifndef REMOTE_COMMAND_LATCH_DECODER_TOP_ASSERT_SVH
`define REMOTE_COMMAND_LATCH_DECODER_TOP_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define RCLD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rcld assertion failed");

// Clocked assertion that is checked during reset as well.
`define RCLD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rcld assertion failed");

`endif

[rtl/rcld_pkg.sv]
// Types, constants and command decoding for the remote command latch decoder.
package rcld_pkg;

  typedef logic [15:0] word_t;

  typedef struct packed {
    logic       func;
    logic [7:0] key_byte;
    logic [7:0] command_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  auth_key;
    logic [15:0] frame_period_ms;
    logic [15:0] idle_timeout_ms;
  } cfg_t;

  // Frame snapshot travelling from the front to the back.
  typedef struct packed {
    logic  valid;
    word_t word;
  } frame_push_t;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AUTH_KEY     = 2'd0,
    CFG_FRAME_PERIOD = 2'd1,
    CFG_IDLE_TIMEOUT = 2'd2
  } cfg_reg_e;

  localparam logic [7:0]  AuthKeyReset     = 8'd21;
  localparam logic [15:0] FramePeriodReset = 16'd50;
  localparam logic [15:0] IdleTimeoutReset = 16'd1000;

  localparam logic [7:0] FrameHdr0 = 8'd68;
  localparam logic [7:0] FrameHdr1 = 8'd84;
  localparam logic [7:0] FrameHdr2 = 8'd89;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] CMD_RELEASE      = 8'd0;
  localparam logic [7:0] CMD_AUTO_TOGGLE  = 8'd1;
  localparam logic [7:0] CMD_STRIP_TOGGLE = 8'd2;
  localparam logic [7:0] CMD_BIT10        = 8'd3;
  localparam logic [7:0] CMD_BIT9         = 8'd4;
  localparam logic [7:0] CMD_BIT1         = 8'd6;
  localparam logic [7:0] CMD_BIT3         = 8'd7;
  localparam logic [7:0] CMD_BIT4         = 8'd8;
  localparam logic [7:0] CMD_BIT11        = 8'd9;
  localparam logic [7:0] CMD_BIT12        = 8'd10;
  localparam logic [7:0] CMD_BIT8         = 8'd11;
  localparam logic [7:0] CMD_BIT7         = 8'd12;
  localparam logic [7:0] CMD_BIT5         = 8'd13;
  localparam logic [7:0] CMD_BIT6         = 8'd14;
  localparam logic [7:0] CMD_LAMP         = 8'd15;
  localparam logic [7:0] CMD_BACK         = 8'd16;
  localparam logic [7:0] CMD_BIT2         = 8'd17;

  // Momentary bit set by a command; latch, lamp, back and unknown codes set none.
  function automatic word_t cmd_mask(logic [7:0] cmd);
    word_t m;
    m = '0;
    case (cmd)
      CMD_BIT10: m[10] = 1'b1;
      CMD_BIT9:  m[9]  = 1'b1;
      CMD_BIT2:  m[2]  = 1'b1;
      CMD_BIT1:  m[1]  = 1'b1;
      CMD_BIT3:  m[3]  = 1'b1;
      CMD_BIT4:  m[4]  = 1'b1;
      CMD_BIT11: m[11] = 1'b1;
      CMD_BIT12: m[12] = 1'b1;
      CMD_BIT8:  m[8]  = 1'b1;
      CMD_BIT7:  m[7]  = 1'b1;
      CMD_BIT5:  m[5]  = 1'b1;
      CMD_BIT6:  m[6]  = 1'b1;
      CMD_LAMP, CMD_BACK, CMD_AUTO_TOGGLE, CMD_STRIP_TOGGLE: m = '0;
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

[rtl/rcld_front.sv]
// Front end: accepts messages and ticks, updates the latches and timers, queues frames.
module rcld_front import rcld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  input  logic        q_full_i,
  output frame_push_t push_o
);

  word_t       word_q, word_d;
  logic        auto_q, auto_d;
  logic        strip_q, strip_d;
  logic        hold_q, hold_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] period_q, period_d;
  logic [15:0] idle_inc, period_inc;
  word_t       rel_word;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign rel_word   = {2'b00, strip_q, 12'h000, auto_q};
  assign idle_inc   = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign period_inc = (period_q == 16'hFFFF) ? period_q : period_q + 16'd1;

  always_comb begin
    word_d      = word_q;
    auto_d      = auto_q;
    strip_d     = strip_q;
    hold_d      = hold_q;
    idle_d      = idle_q;
    period_d    = period_q;
    push_o.valid = 1'b0;
    if (accept) begin
      if (!in_item_i.func) begin
        idle_d = '0;
        if (in_item_i.key_byte == cfg_i.auth_key) begin
          if (in_item_i.command_byte == CMD_RELEASE) begin
            word_d = rel_word;
            hold_d = 1'b0;
          end else if (!hold_q) begin
            if (in_item_i.command_byte == CMD_AUTO_TOGGLE) begin
              auto_d = !auto_q;
            end
            if (in_item_i.command_byte == CMD_STRIP_TOGGLE) begin
              strip_d = !strip_q;
            end
            word_d = word_q | cmd_mask(in_item_i.command_byte);
            hold_d = 1'b1;
          end
        end
      end else begin
        idle_d = idle_inc;
        if (idle_inc >= cfg_i.idle_timeout_ms) begin
          word_d = rel_word;
          hold_d = 1'b0;
        end
        if (period_inc >= cfg_i.frame_period_ms) begin
          period_d     = '0;
          push_o.valid = 1'b1;
        end else begin
          period_d = period_inc;
        end
      end
    end
    push_o.word = word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q   <= '0;
      auto_q   <= 1'b0;
      strip_q  <= 1'b0;
      hold_q   <= 1'b0;
      idle_q   <= '0;
      period_q <= '0;
    end else begin
      word_q   <= word_d;
      auto_q   <= auto_d;
      strip_q  <= strip_d;
      hold_q   <= hold_d;
      idle_q   <= idle_d;
      period_q <= period_d;
    end
  end

endmodule

[rtl/rcld_queue.sv]
// Short queue of output-word snapshots between the front and the back.
module rcld_queue import rcld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  frame_push_t push_i,
  output logic        full_o,
  input  logic        pop_i,
  output frame_push_t head_o
);

  word_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o      = (cnt_q == QCntW'(QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.word  = mem_q[rd_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QCntW'(1);
      2'b01:   cnt_d = cnt_q - QCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/rcld_back.sv]
// Back end: serializes one queued output word into a five-beat frame.
module rcld_back import rcld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  frame_push_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  typedef enum logic [4:0] {
    SEL_HDR0 = 5'b00001,
    SEL_HDR1 = 5'b00010,
    SEL_HDR2 = 5'b00100,
    SEL_LO   = 5'b01000,
    SEL_HI   = 5'b10000
  } byte_sel_e;

  byte_sel_e sel_q, sel_d;
  logic      busy_q, busy_d;
  word_t     word_q;
  logic      fire;
  logic      load;

  assign out_valid_o = busy_q;
  assign fire        = busy_q && out_ready_i;
  // Start the next frame right behind the last beat of the current one.
  assign load        = head_i.valid && (!busy_q || (fire && sel_q == SEL_HI));
  assign pop_o       = load;

  always_comb begin
    sel_d  = sel_q;
    busy_d = busy_q;
    if (load) begin
      sel_d  = SEL_HDR0;
      busy_d = 1'b1;
    end else if (fire) begin
      case (sel_q)
        SEL_HDR0: sel_d = SEL_HDR1;
        SEL_HDR1: sel_d = SEL_HDR2;
        SEL_HDR2: sel_d = SEL_LO;
        SEL_LO:   sel_d = SEL_HI;
        SEL_HI:   busy_d = 1'b0;
        default:  sel_d = SEL_HDR0;
      endcase
    end
  end

  always_comb begin
    out_item_o.frame_last = 1'b0;
    case (sel_q)
      SEL_HDR0: out_item_o.frame_byte = FrameHdr0;
      SEL_HDR1: out_item_o.frame_byte = FrameHdr1;
      SEL_HDR2: out_item_o.frame_byte = FrameHdr2;
      SEL_LO:   out_item_o.frame_byte = word_q[7:0];
      SEL_HI: begin
        out_item_o.frame_byte = word_q[15:8];
        out_item_o.frame_last = 1'b1;
      end
      default:  out_item_o.frame_byte = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= head_i.word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= SEL_HDR0;
      busy_q <= 1'b0;
    end else begin
      sel_q  <= sel_d;
      busy_q <= busy_d;
    end
  end

endmodule

[rtl/remote_command_latch_decoder_top.sv]
// Top level of the remote command latch decoder: configuration registers and datapath.
//
//   Channel  Direction  Signals                                   Beat
//   in       input      in_valid_i / in_ready_o / in_item_i       one message or tick
//   out      output     out_valid_o / out_ready_i / out_item_o    one frame byte
//   cfg      input      cfg_valid_i / cfg_ready_o / cfg_index_i,  one register write
//                       cfg_data_i
//
// The front end takes one input beat per cycle while the queue is not full and updates all state in that cycle.
// A tick that closes a frame period pushes a snapshot of the output word into a
// two-entry queue; the input stalls only while that queue is full.
// The back end drains the queue at five output beats per frame, one per cycle while
// out_ready_i is high, so the frame serializer sets the sustained rate of ticks that
// produce frames.
// Reset restores the configuration defaults and clears all latches, timers and the
// queue; no clearing pass is needed, and configuration writes are always accepted.
module remote_command_latch_decoder_top import rcld_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t        cfg_q, cfg_d;
  frame_push_t push;
  frame_push_t head;
  logic        q_full;
  logic        pop;

  // Configuration writes never stall; an index beyond the register list is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_AUTH_KEY:     cfg_d.auth_key        = cfg_data_i[7:0];
        CFG_FRAME_PERIOD: cfg_d.frame_period_ms = cfg_data_i[15:0];
        CFG_IDLE_TIMEOUT: cfg_d.idle_timeout_ms = cfg_data_i[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auth_key        <= AuthKeyReset;
      cfg_q.frame_period_ms <= FramePeriodReset;
      cfg_q.idle_timeout_ms <= IdleTimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each beat and applies commands, releases and timers.
  rcld_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  // The queue decouples ticks from the slower frame serializer.
  rcld_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  // The back end sends the three header bytes and then the output word, low byte first.
  rcld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[rtl/rcld_checker.sv]
// Port-level checker for the remote command latch decoder and its bind statement.
`include "remote_command_latch_decoder_top_assert.svh"

module rcld_checker import rcld_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input out_item_t           out_item_o
);

  // A stalled output beat holds its value.
  `RCLD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))

  // Output is idle while reset is held.
  `RCLD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o)

  // A frame always opens with its first header byte.
  `RCLD_ASSERT(a_frame_start, $rose(out_valid_o) |-> out_item_o.frame_byte == FrameHdr0)

  // Within a frame the next beat follows at once and is not the last one after the first header byte.
  `RCLD_ASSERT(a_frame_cont,
               out_valid_o && out_ready_i && !out_item_o.frame_last
               |=> out_valid_o)

  `RCLD_ASSERT(a_after_hdr0,
               out_valid_o && out_ready_i && out_item_o.frame_byte == FrameHdr0 &&
               !out_item_o.frame_last |=> out_valid_o && !out_item_o.frame_last)

endmodule

bind remote_command_latch_decoder_top rcld_checker u_rcld_checker (.*);
